>>> design/assert_macros.svh
// Assertion macros shared by the quaternion arithmetic unit.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge except while reset is high.
`define QAU_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define QAU_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/qau_pkg.sv
// Shared types and constants for the quaternion arithmetic unit.
// Depends on nothing; used by the product pipeline and the top level.
package qau_pkg;

   // Operation codes carried in each request word
   typedef enum logic [2:0] {
      OP_ADD      = 3'd0,
      OP_SUB      = 3'd1,
      OP_MUL      = 3'd2,
      OP_SCALE    = 3'd3,
      OP_ROTATE   = 3'd4,
      OP_UNROTATE = 3'd5
   } opcode_type;

   // How the reduce stage of a product pipeline forms its four sums
   typedef enum logic [1:0] {
      MODE_HAM   = 2'd0,
      MODE_SCALE = 2'd1,
      MODE_LIN   = 2'd2
   } mode_type;

   // Control that enters a product pipeline with each word
   typedef struct packed {
      logic     valid;
      mode_type mode;
   } stage_ctl_type;

   // Register stages from request accept to response register
   localparam logic [3:0] PIPE_DEPTH = 4'd7;

endpackage

>>> design/qau_if.sv
// Valid/ready channel interfaces for request and response words.
// Depends on nothing; instantiated around the quaternion arithmetic unit.
interface qau_req_if #(parameter int VALUE_WIDTH = 16);
   logic                          valid;
   logic                          ready;
   logic [2:0]                    opcode;
   logic signed [VALUE_WIDTH-1:0] a_w;
   logic signed [VALUE_WIDTH-1:0] a_x;
   logic signed [VALUE_WIDTH-1:0] a_y;
   logic signed [VALUE_WIDTH-1:0] a_z;
   logic signed [VALUE_WIDTH-1:0] b_w;
   logic signed [VALUE_WIDTH-1:0] b_x;
   logic signed [VALUE_WIDTH-1:0] b_y;
   logic signed [VALUE_WIDTH-1:0] b_z;

   modport source (output valid, opcode, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
                   input ready);
   modport sink (input valid, opcode, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
                 output ready);
endinterface

interface qau_rsp_if #(parameter int VALUE_WIDTH = 16);
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] r_w;
   logic signed [VALUE_WIDTH-1:0] r_x;
   logic signed [VALUE_WIDTH-1:0] r_y;
   logic signed [VALUE_WIDTH-1:0] r_z;
   logic                          saturated;

   modport source (output valid, r_w, r_x, r_y, r_z, saturated, input ready);
   modport sink (input valid, r_w, r_x, r_y, r_z, saturated, output ready);
endinterface

>>> design/quaternion_arithmetic_unit_core.sv
// Quaternion add, subtract, Hamilton product, scale, rotate and unrotate.
// Every opcode takes the same path from request accept to response valid:
// one word per cycle while the sink is ready; two chained 3-stage product
// pipelines and an output register, each stage with its own valid bit and ready.
// Reset (synchronous, active high) clears all valid bits and the check counter.
module quaternion_arithmetic_unit_core #(
   parameter int VALUE_WIDTH = 16,
   parameter int FRAC_BITS   = 12
) (
   input  logic       clock,
   input  logic       reset,
   qau_req_if.sink    req_chan,
   qau_rsp_if.source  rsp_chan
);
   import qau_pkg::*;
   `include "assert_macros.svh"

   localparam int OW       = VALUE_WIDTH + 1;
   localparam int W        = VALUE_WIDTH;
   localparam int SIDE1_W  = 4 * OW + 3;
   localparam int SIDE2_W  = 4 * W + 4;

   logic signed [W-1:0]  req_a [4];
   logic signed [W-1:0]  req_b [4];
   logic signed [OW-1:0] ext_a [4];
   logic signed [OW-1:0] ext_b [4];
   logic signed [OW-1:0] p1_p [4];
   logic signed [OW-1:0] p1_q [4];
   logic signed [OW-1:0] p1_lin [4];
   logic signed [OW-1:0] sec_q [4];
   stage_ctl_type        p1_ctl;
   logic [SIDE1_W-1:0]   p1_side_in;

   logic                 p1_out_valid, p1_out_ready;
   logic signed [W-1:0]  p1_r [4];
   logic [3:0]           p1_clip;
   logic [SIDE1_W-1:0]   p1_side;

   logic signed [OW-1:0] p2_p [4];
   logic signed [OW-1:0] p2_q [4];
   logic signed [OW-1:0] p2_lin [4];
   stage_ctl_type        p2_ctl;
   logic [SIDE2_W-1:0]   p2_side_in;

   logic                 p2_out_valid, p2_out_ready;
   logic signed [W-1:0]  p2_r [4];
   logic [3:0]           p2_clip;
   logic [SIDE2_W-1:0]   p2_side;

   logic                 rsp_v_ff;
   logic signed [W-1:0]  rsp_w_ff, rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic signed [W-1:0]  rsp_w_in, rsp_x_in, rsp_y_in, rsp_z_in;
   logic                 rsp_sat_ff, rsp_sat_in;
   logic                 out_rdy;

   logic [3:0]           inflight_ff, inflight_in;

   assign req_a[0] = req_chan.a_w;
   assign req_a[1] = req_chan.a_x;
   assign req_a[2] = req_chan.a_y;
   assign req_a[3] = req_chan.a_z;
   assign req_b[0] = req_chan.b_w;
   assign req_b[1] = req_chan.b_x;
   assign req_b[2] = req_chan.b_y;
   assign req_b[3] = req_chan.b_z;

   // Pick first-product operands and the second-product right factor
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         ext_a[i]  = OW'(req_a[i]);
         ext_b[i]  = OW'(req_b[i]);
         p1_p[i]   = ext_a[i];
         p1_q[i]   = ext_b[i];
         p1_lin[i] = '0;
         sec_q[i]  = ext_a[i];
      end
      p1_ctl.valid = req_chan.valid;
      p1_ctl.mode  = MODE_HAM;
      case (opcode_type'(req_chan.opcode))
         OP_ADD: begin
            p1_ctl.mode = MODE_LIN;
            for (int i = 0; i < 4; i++) begin
               p1_lin[i] = ext_a[i] + ext_b[i];
            end
         end
         OP_SUB: begin
            p1_ctl.mode = MODE_LIN;
            for (int i = 0; i < 4; i++) begin
               p1_lin[i] = ext_a[i] - ext_b[i];
            end
         end
         OP_MUL: begin
            p1_ctl.mode = MODE_HAM;
         end
         OP_SCALE: begin
            p1_ctl.mode = MODE_SCALE;
         end
         OP_ROTATE: begin
            // conj(a) * (0, v), then times a
            p1_q[0] = '0;
            for (int i = 1; i < 4; i++) begin
               p1_p[i] = -ext_a[i];
            end
         end
         OP_UNROTATE: begin
            // a * (0, v), then times conj(a)
            p1_q[0] = '0;
            for (int i = 1; i < 4; i++) begin
               sec_q[i] = -ext_a[i];
            end
         end
         default: begin
            p1_ctl.mode = MODE_HAM;
         end
      endcase
      for (int i = 0; i < 4; i++) begin
         p1_side_in[OW*i +: OW] = sec_q[i];
      end
      p1_side_in[4*OW +: 3] = req_chan.opcode;
   end

   qau_prod #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .FRAC_BITS   (FRAC_BITS),
      .SIDE_WIDTH  (SIDE1_W)
   ) u_prod_first (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (p1_ctl),
      .in_ready  (req_chan.ready),
      .in_p      (p1_p),
      .in_q      (p1_q),
      .in_lin    (p1_lin),
      .in_side   (p1_side_in),
      .out_valid (p1_out_valid),
      .out_ready (p1_out_ready),
      .out_r     (p1_r),
      .out_clip  (p1_clip),
      .out_side  (p1_side)
   );

   // Feed the saturated first product into the second product
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         p2_p[i]   = OW'(p1_r[i]);
         p2_q[i]   = p1_side[OW*i +: OW];
         p2_lin[i] = '0;
         p2_side_in[W*i +: W] = p1_r[i];
      end
      p2_side_in[4*W]       = |p1_clip;
      p2_side_in[4*W+1 +: 3] = p1_side[4*OW +: 3];
      p2_ctl.valid = p1_out_valid;
      p2_ctl.mode  = MODE_HAM;
   end

   qau_prod #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .FRAC_BITS   (FRAC_BITS),
      .SIDE_WIDTH  (SIDE2_W)
   ) u_prod_second (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (p2_ctl),
      .in_ready  (p1_out_ready),
      .in_p      (p2_p),
      .in_q      (p2_q),
      .in_lin    (p2_lin),
      .in_side   (p2_side_in),
      .out_valid (p2_out_valid),
      .out_ready (p2_out_ready),
      .out_r     (p2_r),
      .out_clip  (p2_clip),
      .out_side  (p2_side)
   );

   // Select the final word by opcode
   always_comb begin
      rsp_w_in   = '0;
      rsp_x_in   = '0;
      rsp_y_in   = '0;
      rsp_z_in   = '0;
      rsp_sat_in = 1'b0;
      case (opcode_type'(p2_side[4*W+1 +: 3]))
         OP_ADD, OP_SUB, OP_MUL, OP_SCALE: begin
            rsp_w_in   = p2_side[0 +: W];
            rsp_x_in   = p2_side[W +: W];
            rsp_y_in   = p2_side[2*W +: W];
            rsp_z_in   = p2_side[3*W +: W];
            rsp_sat_in = p2_side[4*W];
         end
         OP_ROTATE, OP_UNROTATE: begin
            // real part of the final product is dropped
            rsp_x_in   = p2_r[1];
            rsp_y_in   = p2_r[2];
            rsp_z_in   = p2_r[3];
            rsp_sat_in = p2_side[4*W] | (|p2_clip[3:1]);
         end
         default: begin
            rsp_sat_in = 1'b0;
         end
      endcase
   end

   // Output register: hold while the sink stalls
   assign out_rdy      = !rsp_v_ff || rsp_chan.ready;
   assign p2_out_ready = out_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (out_rdy) begin
         rsp_v_ff <= p2_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_rdy) begin
         rsp_w_ff   <= rsp_w_in;
         rsp_x_ff   <= rsp_x_in;
         rsp_y_ff   <= rsp_y_in;
         rsp_z_ff   <= rsp_z_in;
         rsp_sat_ff <= rsp_sat_in;
      end
   end

   assign rsp_chan.valid     = rsp_v_ff;
   assign rsp_chan.r_w       = rsp_w_ff;
   assign rsp_chan.r_x       = rsp_x_ff;
   assign rsp_chan.r_y       = rsp_y_ff;
   assign rsp_chan.r_z       = rsp_z_ff;
   assign rsp_chan.saturated = rsp_sat_ff;

   // Count words accepted but not yet delivered
   always_comb begin
      inflight_in = inflight_ff + 4'(req_chan.valid & req_chan.ready)
                    - 4'(rsp_chan.valid & rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   `QAU_ASSERT_ALWAYS(a_reset_drops_rsp, clock, $past(reset) |-> !rsp_chan.valid, "response valid right after reset")
   `QAU_ASSERT(a_inflight_bound, clock, reset, inflight_ff <= PIPE_DEPTH, "more words in flight than pipeline stages")
   `QAU_ASSERT(a_rsp_has_source, clock, reset, rsp_chan.valid |-> inflight_ff != 4'd0, "response word with no accepted request")

endmodule

>>> design/qau_prod.sv
// Three-stage product pipeline: 4x4 multiply, round and reduce, saturate.
// Depends on qau_pkg; instantiated twice by the top level.
module qau_prod #(
   parameter int VALUE_WIDTH = 16,
   parameter int FRAC_BITS   = 12,
   parameter int SIDE_WIDTH  = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  qau_pkg::stage_ctl_type        in_ctl,
   output logic                          in_ready,
   input  logic signed [VALUE_WIDTH:0]   in_p [4],
   input  logic signed [VALUE_WIDTH:0]   in_q [4],
   input  logic signed [VALUE_WIDTH:0]   in_lin [4],
   input  logic [SIDE_WIDTH-1:0]         in_side,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [VALUE_WIDTH-1:0] out_r [4],
   output logic [3:0]                    out_clip,
   output logic [SIDE_WIDTH-1:0]         out_side
);
   import qau_pkg::*;

   localparam int OW = VALUE_WIDTH + 1;
   localparam int PW = 2 * OW;
   localparam int RW = PW + 1;
   localparam int SW = RW + 2;
   localparam logic signed [RW-1:0] HALF = {{(RW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
   localparam logic signed [VALUE_WIDTH-1:0] RMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic signed [VALUE_WIDTH-1:0] RMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
   localparam logic signed [SW-1:0] SMAX = SW'(RMAX);
   localparam logic signed [SW-1:0] SMIN = SW'(RMIN);

   logic                          mul_rdy, sum_rdy, sat_rdy;

   logic                          mul_v_ff;
   mode_type                      mul_mode_ff;
   logic signed [PW-1:0]          mul_prod_ff [4][4];
   logic signed [PW-1:0]          mul_prod_in [4][4];
   logic signed [OW-1:0]          mul_lin_ff [4];
   logic [SIDE_WIDTH-1:0]         mul_side_ff;

   logic signed [SW-1:0]          rnd [4][4];
   logic                          sum_v_ff;
   logic signed [SW-1:0]          sum_ff [4];
   logic signed [SW-1:0]          sum_in [4];
   logic [SIDE_WIDTH-1:0]         sum_side_ff;

   logic                          sat_v_ff;
   logic signed [VALUE_WIDTH-1:0] sat_r_ff [4];
   logic signed [VALUE_WIDTH-1:0] sat_r_in [4];
   logic [3:0]                    sat_clip_ff;
   logic [3:0]                    sat_clip_in;
   logic [SIDE_WIDTH-1:0]         sat_side_ff;

   // Each stage advances when empty or when the stage below takes its word
   assign sat_rdy  = !sat_v_ff || out_ready;
   assign sum_rdy  = !sum_v_ff || sat_rdy;
   assign mul_rdy  = !mul_v_ff || sum_rdy;
   assign in_ready = mul_rdy;

   // Form all sixteen cross products
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            mul_prod_in[i][j] = PW'(in_p[i]) * PW'(in_q[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_v_ff <= 1'b0;
      end else if (mul_rdy) begin
         mul_v_ff <= in_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (mul_rdy) begin
         mul_mode_ff <= in_ctl.mode;
         mul_prod_ff <= mul_prod_in;
         mul_lin_ff  <= in_lin;
         mul_side_ff <= in_side;
      end
   end

   // Round each product to nearest, ties up, then reduce
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            rnd[i][j] = SW'((RW'(mul_prod_ff[i][j]) + HALF) >>> FRAC_BITS);
         end
      end
      case (mul_mode_ff)
         MODE_HAM: begin
            sum_in[0] = rnd[0][0] - rnd[1][1] - rnd[2][2] - rnd[3][3];
            sum_in[1] = rnd[0][1] + rnd[1][0] + rnd[2][3] - rnd[3][2];
            sum_in[2] = rnd[0][2] + rnd[2][0] + rnd[3][1] - rnd[1][3];
            sum_in[3] = rnd[0][3] + rnd[3][0] + rnd[1][2] - rnd[2][1];
         end
         MODE_SCALE: begin
            for (int i = 0; i < 4; i++) begin
               sum_in[i] = rnd[i][0];
            end
         end
         MODE_LIN: begin
            for (int i = 0; i < 4; i++) begin
               sum_in[i] = SW'(mul_lin_ff[i]);
            end
         end
         default: begin
            for (int i = 0; i < 4; i++) begin
               sum_in[i] = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_v_ff <= 1'b0;
      end else if (sum_rdy) begin
         sum_v_ff <= mul_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (sum_rdy) begin
         sum_ff      <= sum_in;
         sum_side_ff <= mul_side_ff;
      end
   end

   // Clip each sum to the value range and flag it
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         if (sum_ff[i] > SMAX) begin
            sat_r_in[i]    = RMAX;
            sat_clip_in[i] = 1'b1;
         end else if (sum_ff[i] < SMIN) begin
            sat_r_in[i]    = RMIN;
            sat_clip_in[i] = 1'b1;
         end else begin
            sat_r_in[i]    = sum_ff[i][VALUE_WIDTH-1:0];
            sat_clip_in[i] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sat_v_ff <= 1'b0;
      end else if (sat_rdy) begin
         sat_v_ff <= sum_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (sat_rdy) begin
         sat_r_ff    <= sat_r_in;
         sat_clip_ff <= sat_clip_in;
         sat_side_ff <= sum_side_ff;
      end
   end

   assign out_valid = sat_v_ff;
   assign out_r     = sat_r_ff;
   assign out_clip  = sat_clip_ff;
   assign out_side  = sat_side_ff;

endmodule
